// ----- hw/rtl/tapid_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tapid_pkg
// Shared types, register map and arithmetic constants for the two-axis
// attitude PID core.
// ----------------------------------------------------------------------------
package tapid_pkg;

    localparam int ACCUM_BITS_DEF = 48;
    localparam int DRIVE_BITS_DEF = 24;

    localparam int FIELD_W   = 16;
    localparam int GAIN_W    = 16;
    localparam int ERR_W     = FIELD_W + 1;
    localparam int MUL_W     = 2 * ERR_W;
    localparam int PD_W      = MUL_W + 1;
    localparam int HALF_W    = 32;
    localparam int PART_W    = GAIN_W + HALF_W;
    localparam int CAT_W     = PART_W + HALF_W;
    localparam int CHUNK_W   = 16;
    localparam int REM_W     = 20;
    localparam int DIVT_W    = REM_W + CHUNK_W;
    localparam int Q_FRAC    = 12;

    // floor(t / 1e6) = floor((t >> 6) / 15625), exact for t < 2^36
    localparam logic [REM_W-1:0] DIV_CONST   = 20'd1000000;
    localparam int               DIV_SHIFT   = 6;
    localparam int               RECIP_W     = 31;
    localparam logic [RECIP_W-1:0] RECIP_MULT = 31'd1125899907;
    localparam int               RECIP_SHIFT = 44;
    localparam int               RECIP_PW    = DIVT_W - DIV_SHIFT + RECIP_W;

    localparam int APB_AW = 5;
    localparam int APB_DW = 32;
    localparam int REG_IW = 3;

    typedef enum logic [REG_IW-1:0] {
        REG_ROLL_KP  = 3'd0,
        REG_ROLL_KI  = 3'd1,
        REG_ROLL_KD  = 3'd2,
        REG_PITCH_KP = 3'd3,
        REG_PITCH_KI = 3'd4,
        REG_PITCH_KD = 3'd5
    } t_reg_idx;

    localparam logic [GAIN_W-1:0] RST_ROLL_KP  = 16'd4096;
    localparam logic [GAIN_W-1:0] RST_ROLL_KI  = 16'd2867;
    localparam logic [GAIN_W-1:0] RST_ROLL_KD  = 16'd1229;
    localparam logic [GAIN_W-1:0] RST_PITCH_KP = 16'd6144;
    localparam logic [GAIN_W-1:0] RST_PITCH_KI = 16'd4506;
    localparam logic [GAIN_W-1:0] RST_PITCH_KD = 16'd2048;

    typedef struct packed {
        logic [GAIN_W-1:0] kp;
        logic [GAIN_W-1:0] ki;
        logic [GAIN_W-1:0] kd;
    } t_gains;

    typedef struct packed {
        logic start;
        logic ack;
    } t_lane_ctl;

    typedef struct packed {
        logic idle;
        logic done;
    } t_lane_sts;

endpackage
`default_nettype wire

// ----- hw/rtl/two_axis_attitude_pid_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Each sample passes through increment, accumulate, low and high partial products, a join,
// the per-lane radix-2^16 divide-by-1e6 loop (a multiply step and a remainder step per
// digit), a sum and a saturation; a lane takes no new sample until its result is accepted.
// Input is taken again as soon as both lanes are free; a finished result may still wait.
// Reset (synchronous, active low) clears both integrals, the output valid and
// restores the default gains.
// ----------------------------------------------------------------------------
// two_axis_attitude_pid_core
// Roll and pitch PID with derivative on measurement, one lane per axis,
// APB gain registers.
// ----------------------------------------------------------------------------
module two_axis_attitude_pid_core import tapid_pkg::*; #(
    parameter int ACCUM_BITS = ACCUM_BITS_DEF,
    parameter int DRIVE_BITS = DRIVE_BITS_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_in_valid,
    output logic                            o_in_ready,
    input  wire logic signed [FIELD_W-1:0]  i_target_roll,
    input  wire logic signed [FIELD_W-1:0]  i_measured_roll,
    input  wire logic signed [FIELD_W-1:0]  i_rate_x,
    input  wire logic signed [FIELD_W-1:0]  i_target_pitch,
    input  wire logic signed [FIELD_W-1:0]  i_measured_pitch,
    input  wire logic signed [FIELD_W-1:0]  i_rate_y,
    input  wire logic        [FIELD_W-1:0]  i_sample_time_us,
    output logic                            o_out_valid,
    input  wire logic                       i_out_ready,
    output logic signed [DRIVE_BITS-1:0]    o_roll_drive,
    output logic signed [DRIVE_BITS-1:0]    o_pitch_drive,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [APB_AW-1:0]          paddr,
    input  wire logic [APB_DW-1:0]          pwdata,
    output logic [APB_DW-1:0]               prdata,
    output logic                            pready
);

    t_gains     r_roll_gains;
    t_gains     r_pitch_gains;
    t_lane_ctl  lane_ctl;
    t_lane_sts  roll_sts;
    t_lane_sts  pitch_sts;
    logic signed [DRIVE_BITS-1:0] roll_drive;
    logic signed [DRIVE_BITS-1:0] pitch_drive;
    logic       merge_ack;
    t_reg_idx   reg_idx;
    logic [GAIN_W-1:0] wr_val;

    assign reg_idx = t_reg_idx'(paddr[APB_AW-1:2]);
    assign wr_val  = pwdata[GAIN_W-1:0];
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_roll_gains.kp  <= RST_ROLL_KP;
            r_roll_gains.ki  <= RST_ROLL_KI;
            r_roll_gains.kd  <= RST_ROLL_KD;
            r_pitch_gains.kp <= RST_PITCH_KP;
            r_pitch_gains.ki <= RST_PITCH_KI;
            r_pitch_gains.kd <= RST_PITCH_KD;
        end else if (psel & penable & pwrite & pready) begin
            unique case (reg_idx)
                REG_ROLL_KP:  r_roll_gains.kp  <= wr_val;
                REG_ROLL_KI:  r_roll_gains.ki  <= wr_val;
                REG_ROLL_KD:  r_roll_gains.kd  <= wr_val;
                REG_PITCH_KP: r_pitch_gains.kp <= wr_val;
                REG_PITCH_KI: r_pitch_gains.ki <= wr_val;
                REG_PITCH_KD: r_pitch_gains.kd <= wr_val;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_ROLL_KP:  prdata = APB_DW'(r_roll_gains.kp);
            REG_ROLL_KI:  prdata = APB_DW'(r_roll_gains.ki);
            REG_ROLL_KD:  prdata = APB_DW'(r_roll_gains.kd);
            REG_PITCH_KP: prdata = APB_DW'(r_pitch_gains.kp);
            REG_PITCH_KI: prdata = APB_DW'(r_pitch_gains.ki);
            REG_PITCH_KD: prdata = APB_DW'(r_pitch_gains.kd);
            default:      prdata = '0;
        endcase
    end

    assign o_in_ready     = roll_sts.idle & pitch_sts.idle;
    assign lane_ctl.start = i_in_valid & o_in_ready;
    assign lane_ctl.ack   = merge_ack;

    tapid_lane #(
        .ACCUM_BITS (ACCUM_BITS),
        .DRIVE_BITS (DRIVE_BITS)
    ) u_roll_lane (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_ctl            (lane_ctl),
        .i_gains          (r_roll_gains),
        .i_target         (i_target_roll),
        .i_measured       (i_measured_roll),
        .i_rate           (i_rate_x),
        .i_sample_time_us (i_sample_time_us),
        .o_sts            (roll_sts),
        .o_drive          (roll_drive)
    );

    tapid_lane #(
        .ACCUM_BITS (ACCUM_BITS),
        .DRIVE_BITS (DRIVE_BITS)
    ) u_pitch_lane (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_ctl            (lane_ctl),
        .i_gains          (r_pitch_gains),
        .i_target         (i_target_pitch),
        .i_measured       (i_measured_pitch),
        .i_rate           (i_rate_y),
        .i_sample_time_us (i_sample_time_us),
        .o_sts            (pitch_sts),
        .o_drive          (pitch_drive)
    );

    tapid_merge #(
        .DRIVE_BITS (DRIVE_BITS)
    ) u_merge (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_roll_sts    (roll_sts),
        .i_pitch_sts   (pitch_sts),
        .i_roll_drive  (roll_drive),
        .i_pitch_drive (pitch_drive),
        .o_ack         (merge_ack),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_roll_drive  (o_roll_drive),
        .o_pitch_drive (o_pitch_drive)
    );

endmodule
`default_nettype wire

// ----- hw/rtl/tapid_lane.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tapid_lane
// One axis: error, saturating integral, exact integral scaling by 1e6 via
// radix-2^16 long division with a reciprocal multiply, drive saturation.
// ----------------------------------------------------------------------------
module tapid_lane import tapid_pkg::*; #(
    parameter int ACCUM_BITS = ACCUM_BITS_DEF,
    parameter int DRIVE_BITS = DRIVE_BITS_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire t_lane_ctl                    i_ctl,
    input  wire t_gains                       i_gains,
    input  wire logic signed [FIELD_W-1:0]    i_target,
    input  wire logic signed [FIELD_W-1:0]    i_measured,
    input  wire logic signed [FIELD_W-1:0]    i_rate,
    input  wire logic        [FIELD_W-1:0]    i_sample_time_us,
    output t_lane_sts                         o_sts,
    output logic signed [DRIVE_BITS-1:0]      o_drive
);

    localparam int SUM_W  = ACCUM_BITS + 2;
    localparam int TERM_W = ACCUM_BITS + 4;
    localparam int NCH    = (ACCUM_BITS + GAIN_W + CHUNK_W - 1) / CHUNK_W;
    localparam int NUM_W  = NCH * CHUNK_W;
    localparam int CNT_W  = $clog2(NCH);

    localparam logic signed [SUM_W-1:0]  ACC_MAX = {3'b000, {(ACCUM_BITS-1){1'b1}}};
    localparam logic signed [SUM_W-1:0]  ACC_MIN = ~ACC_MAX;
    localparam logic signed [TERM_W-1:0] DRV_MAX = TERM_W'({1'b0, {(DRIVE_BITS-1){1'b1}}});
    localparam logic signed [TERM_W-1:0] DRV_MIN = ~DRV_MAX;

    typedef enum logic [10:0] {
        ST_IDLE = 11'b000_0000_0001,
        ST_INC  = 11'b000_0000_0010,
        ST_ACC  = 11'b000_0000_0100,
        ST_MLO  = 11'b000_0000_1000,
        ST_MHI  = 11'b000_0001_0000,
        ST_CAT  = 11'b000_0010_0000,
        ST_DMUL = 11'b000_0100_0000,
        ST_DREM = 11'b000_1000_0000,
        ST_SUM  = 11'b001_0000_0000,
        ST_SAT  = 11'b010_0000_0000,
        ST_DONE = 11'b100_0000_0000
    } t_state;

    t_state                    r_state, n_state;
    logic signed [ACCUM_BITS-1:0] r_accum, n_accum;
    logic        [CNT_W-1:0]   r_cnt, n_cnt;

    logic signed [ERR_W-1:0]   r_err;
    logic signed [ERR_W-1:0]   r_nrate;
    logic        [FIELD_W-1:0] r_dt;
    logic signed [MUL_W-1:0]   r_inc;
    logic                      r_neg;
    logic        [ACCUM_BITS-1:0] r_mag;
    logic signed [MUL_W-1:0]   r_pterm;
    logic signed [MUL_W-1:0]   r_dterm;
    logic        [PART_W-1:0]  r_plo;
    logic        [PART_W-1:0]  r_phi;
    logic signed [PD_W-1:0]    r_pd;
    logic        [NUM_W-1:0]   r_num;
    logic        [REM_W-1:0]   r_rem;
    logic        [DIVT_W-1:0]  r_t;
    logic        [CHUNK_W-1:0] r_q;
    logic        [NUM_W-1:0]   r_quo;
    logic signed [TERM_W-1:0]  r_sum;
    logic signed [DRIVE_BITS-1:0] r_drive;

    logic signed [ERR_W-1:0]   err_in;
    logic signed [ERR_W-1:0]   nrate_in;
    logic signed [MUL_W-1:0]   inc_full;
    logic signed [SUM_W-1:0]   acc_sum;
    logic signed [ACCUM_BITS-1:0] acc_sat;
    logic        [2*HALF_W-1:0] mag_ext;
    logic        [CAT_W-1:0]   cat_sum;
    logic        [DIVT_W-1:0]  t_cur;
    logic        [RECIP_PW-1:0] recip_prod;
    logic        [DIVT_W-1:0]  rem_full;
    logic signed [TERM_W-1:0]  quo_s;
    logic signed [TERM_W-1:0]  iterm;
    logic signed [TERM_W-1:0]  shifted;

    assign err_in   = ERR_W'(i_target) - ERR_W'(i_measured);
    assign nrate_in = -ERR_W'(i_rate);
    assign inc_full = r_err * $signed({1'b0, r_dt});

    assign acc_sum = SUM_W'(r_accum) + SUM_W'(r_inc);

    always_comb begin
        if (acc_sum > ACC_MAX) begin
            acc_sat = ACC_MAX[ACCUM_BITS-1:0];
        end else if (acc_sum < ACC_MIN) begin
            acc_sat = ACC_MIN[ACCUM_BITS-1:0];
        end else begin
            acc_sat = acc_sum[ACCUM_BITS-1:0];
        end
    end

    assign mag_ext    = (2*HALF_W)'(r_mag);
    assign cat_sum    = {r_phi, {HALF_W{1'b0}}} + {{HALF_W{1'b0}}, r_plo};
    assign t_cur      = {r_rem, r_num[NUM_W-1 -: CHUNK_W]};
    assign recip_prod = t_cur[DIVT_W-1:DIV_SHIFT] * RECIP_MULT;
    assign rem_full   = r_t - (DIVT_W'(r_q) * DIVT_W'(DIV_CONST));
    assign quo_s      = $signed(r_quo[TERM_W-1:0]);
    assign iterm      = r_neg ? -quo_s : quo_s;
    assign shifted    = r_sum >>> Q_FRAC;

    always_comb begin
        n_state = r_state;
        n_accum = r_accum;
        n_cnt   = r_cnt;
        unique case (r_state)
            ST_IDLE: begin
                if (i_ctl.start) begin
                    n_state = ST_INC;
                end
            end
            ST_INC:  n_state = ST_ACC;
            ST_ACC: begin
                n_accum = acc_sat;
                n_state = ST_MLO;
            end
            ST_MLO:  n_state = ST_MHI;
            ST_MHI:  n_state = ST_CAT;
            ST_CAT: begin
                n_cnt   = '0;
                n_state = ST_DMUL;
            end
            ST_DMUL: n_state = ST_DREM;
            ST_DREM: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(NCH-1)) begin
                    n_state = ST_SUM;
                end else begin
                    n_state = ST_DMUL;
                end
            end
            ST_SUM:  n_state = ST_SAT;
            ST_SAT:  n_state = ST_DONE;
            ST_DONE: begin
                if (i_ctl.ack) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_accum <= '0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_accum <= n_accum;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                r_err   <= err_in;
                r_nrate <= nrate_in;
                r_dt    <= i_sample_time_us;
            end
            ST_INC: r_inc <= inc_full;
            ST_ACC: begin
                r_neg   <= acc_sat[ACCUM_BITS-1];
                r_mag   <= acc_sat[ACCUM_BITS-1] ? ACCUM_BITS'(0) - ACCUM_BITS'(acc_sat)
                                                 : ACCUM_BITS'(acc_sat);
                r_pterm <= $signed({1'b0, i_gains.kp}) * r_err;
            end
            ST_MLO: r_plo <= i_gains.ki * mag_ext[HALF_W-1:0];
            ST_MHI: begin
                r_phi   <= i_gains.ki * mag_ext[2*HALF_W-1:HALF_W];
                r_dterm <= $signed({1'b0, i_gains.kd}) * r_nrate;
            end
            ST_CAT: begin
                r_num <= cat_sum[NUM_W-1:0];
                r_rem <= '0;
                r_pd  <= PD_W'(r_pterm) + PD_W'(r_dterm);
            end
            ST_DMUL: begin
                r_t   <= t_cur;
                r_q   <= recip_prod[RECIP_SHIFT +: CHUNK_W];
                r_num <= r_num << CHUNK_W;
            end
            ST_DREM: begin
                r_rem <= rem_full[REM_W-1:0];
                r_quo <= {r_quo[NUM_W-CHUNK_W-1:0], r_q};
            end
            ST_SUM: r_sum <= TERM_W'(r_pd) + iterm;
            ST_SAT: begin
                if (shifted > DRV_MAX) begin
                    r_drive <= DRV_MAX[DRIVE_BITS-1:0];
                end else if (shifted < DRV_MIN) begin
                    r_drive <= DRV_MIN[DRIVE_BITS-1:0];
                end else begin
                    r_drive <= shifted[DRIVE_BITS-1:0];
                end
            end
            ST_DONE: ;
            default: ;
        endcase
    end

    assign o_sts.idle = (r_state == ST_IDLE);
    assign o_sts.done = (r_state == ST_DONE);
    assign o_drive    = r_drive;

endmodule
`default_nettype wire

// ----- hw/rtl/tapid_merge.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tapid_merge
// Joins the roll and pitch lanes into one result beat and holds it in the
// output register until the sink takes it.
// ----------------------------------------------------------------------------
module tapid_merge import tapid_pkg::*; #(
    parameter int DRIVE_BITS = DRIVE_BITS_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire t_lane_sts                  i_roll_sts,
    input  wire t_lane_sts                  i_pitch_sts,
    input  wire logic signed [DRIVE_BITS-1:0] i_roll_drive,
    input  wire logic signed [DRIVE_BITS-1:0] i_pitch_drive,
    output logic                            o_ack,
    output logic                            o_out_valid,
    input  wire logic                       i_out_ready,
    output logic signed [DRIVE_BITS-1:0]    o_roll_drive,
    output logic signed [DRIVE_BITS-1:0]    o_pitch_drive
);

    logic                          r_valid, n_valid;
    logic signed [DRIVE_BITS-1:0]  r_roll;
    logic signed [DRIVE_BITS-1:0]  r_pitch;
    logic                          load;

    assign load = i_roll_sts.done & i_pitch_sts.done & (~r_valid | i_out_ready);

    always_comb begin
        n_valid = r_valid;
        if (load) begin
            n_valid = 1'b1;
        end else if (i_out_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_roll  <= i_roll_drive;
            r_pitch <= i_pitch_drive;
        end
    end

    assign o_ack         = load;
    assign o_out_valid   = r_valid;
    assign o_roll_drive  = r_roll;
    assign o_pitch_drive = r_pitch;

endmodule
`default_nettype wire

// ----- hw/rtl/tapid_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tapid_checker
// Port-level checks on the PID core's handshakes, bound to the top level.
// ----------------------------------------------------------------------------
module tapid_checker import tapid_pkg::*; #(
    parameter int DRIVE_BITS = DRIVE_BITS_DEF
) (
    input wire logic                     i_clk,
    input wire logic                     i_rst_n,
    input wire logic                     i_in_valid,
    input wire logic                     o_in_ready,
    input wire logic                     o_out_valid,
    input wire logic                     i_out_ready,
    input wire logic [DRIVE_BITS-1:0]    o_roll_drive,
    input wire logic [DRIVE_BITS-1:0]    o_pitch_drive
);

    // no result beat straight out of reset
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // an accepted item occupies the lanes
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input ready while lanes busy");

    // a new result only comes from lanes that were working
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(!o_in_ready))
        else $error("result without work in flight");

    // stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_roll_drive) && $stable(o_pitch_drive)))
        else $error("stalled result beat changed");

endmodule

bind two_axis_attitude_pid_core tapid_checker #(.DRIVE_BITS(DRIVE_BITS)) u_tapid_checker (.*);
`default_nettype wire

// ----- test/two_axis_attitude_pid_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_axis_attitude_pid_core_tb
// Drives attitude samples and APB gain writes into the two-axis PID core and
// scores each drive beat against a bit-exact predictor. The predictor keeps
// its own gains and integrals. Coverage includes field extremes, zero and
// maximum sample times, ignored register writes and a back-to-back stretch
// that pushes both integrals hard. Both handshakes idle and stall at random.
// ----------------------------------------------------------------------------
module two_axis_attitude_pid_core_tb;
    import tapid_pkg::*;

    localparam int AX_ROLL  = 0;
    localparam int AX_PITCH = 1;
    localparam logic [REG_IW-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [REG_IW-1:0] REG_SPARE_HI = 3'd7;
    localparam longint ACC_MAX = (longint'(1) <<< (ACCUM_BITS_DEF - 1)) - 1;
    localparam longint ACC_MIN = -ACC_MAX - 1;
    localparam longint DRV_MAX = (longint'(1) <<< (DRIVE_BITS_DEF - 1)) - 1;
    localparam longint DRV_MIN = -DRV_MAX - 1;
    localparam longint unsigned MICRO = 64'd1000000;
    localparam int     DRAIN_CYCLES = 24;
    localparam int     IDLE_PCT     = 17;
    localparam int     PHASES       = 8;
    localparam int     PHASE_ITEMS  = 115;
    localparam int     SAT_ITEMS    = 60;
    localparam longint LIMIT_NS     = 60_000_000;

    typedef logic signed [DRIVE_BITS_DEF-1:0] drive_t;

    typedef struct {
        logic signed [FIELD_W-1:0] tgt_roll;
        logic signed [FIELD_W-1:0] meas_roll;
        logic signed [FIELD_W-1:0] rate_x;
        logic signed [FIELD_W-1:0] tgt_pitch;
        logic signed [FIELD_W-1:0] meas_pitch;
        logic signed [FIELD_W-1:0] rate_y;
        logic        [FIELD_W-1:0] dt;
    } attitude_sample_t;

    typedef struct {
        drive_t roll;
        drive_t pitch;
    } drive_pair_t;

    typedef enum int {GEN_NOISE, GEN_TRACK, GEN_PUSH, GEN_DT_EDGE} gen_mode_t;
    typedef enum int {GAINS_ZERO, GAINS_MAX, GAINS_RANDOM} gain_style_t;

    class drive_scoreboard;
        logic [GAIN_W-1:0] kp[2] = '{RST_ROLL_KP, RST_PITCH_KP};
        logic [GAIN_W-1:0] ki[2] = '{RST_ROLL_KI, RST_PITCH_KI};
        logic [GAIN_W-1:0] kd[2] = '{RST_ROLL_KD, RST_PITCH_KD};
        longint            integ[2] = '{0, 0};
        drive_pair_t       drive_q[$];
        int                errors = 0;
        int                checked = 0;

        function void set_gain(logic [REG_IW-1:0] idx, logic [APB_DW-1:0] v);
            case (idx)
                REG_ROLL_KP:  kp[AX_ROLL]  = v[GAIN_W-1:0];
                REG_ROLL_KI:  ki[AX_ROLL]  = v[GAIN_W-1:0];
                REG_ROLL_KD:  kd[AX_ROLL]  = v[GAIN_W-1:0];
                REG_PITCH_KP: kp[AX_PITCH] = v[GAIN_W-1:0];
                REG_PITCH_KI: ki[AX_PITCH] = v[GAIN_W-1:0];
                REG_PITCH_KD: kd[AX_PITCH] = v[GAIN_W-1:0];
                default: ;
            endcase
        endfunction

        function logic [GAIN_W-1:0] gain_of(t_reg_idx idx);
            case (idx)
                REG_ROLL_KP:  return kp[AX_ROLL];
                REG_ROLL_KI:  return ki[AX_ROLL];
                REG_ROLL_KD:  return kd[AX_ROLL];
                REG_PITCH_KP: return kp[AX_PITCH];
                REG_PITCH_KI: return ki[AX_PITCH];
                default:      return kd[AX_PITCH];
            endcase
        endfunction

        // one axis: saturating integral, truncated I term, floored Q.12 sum
        function drive_t axis_drive(int ax, logic signed [FIELD_W-1:0] tgt,
                                    logic signed [FIELD_W-1:0] meas,
                                    logic signed [FIELD_W-1:0] rate,
                                    logic [FIELD_W-1:0] dt);
            longint          err, inc, acc, iterm, total, drv;
            longint unsigned mag, iq;
            err = longint'(tgt) - longint'(meas);
            inc = err * longint'(dt);
            acc = integ[ax];
            if (inc > 0 && acc > ACC_MAX - inc)
                acc = ACC_MAX;
            else if (inc < 0 && acc < ACC_MIN - inc)
                acc = ACC_MIN;
            else
                acc = acc + inc;
            integ[ax] = acc;
            mag = (acc < 0) ? -acc : acc;
            iq = (mag * 64'(ki[ax])) / MICRO;
            iterm = (acc < 0) ? -longint'(iq) : longint'(iq);
            total = longint'(kp[ax]) * err + iterm - longint'(kd[ax]) * longint'(rate);
            drv = total >>> Q_FRAC;
            if (drv > DRV_MAX)
                drv = DRV_MAX;
            if (drv < DRV_MIN)
                drv = DRV_MIN;
            return drv[DRIVE_BITS_DEF-1:0];
        endfunction

        function void note_sample(attitude_sample_t s);
            drive_pair_t d;
            d.roll  = axis_drive(AX_ROLL, s.tgt_roll, s.meas_roll, s.rate_x, s.dt);
            d.pitch = axis_drive(AX_PITCH, s.tgt_pitch, s.meas_pitch, s.rate_y, s.dt);
            drive_q.push_back(d);
        endfunction

        function void check_drive(drive_t roll, drive_t pitch);
            drive_pair_t d;
            if (drive_q.size() == 0) begin
                errors++;
                $error("drive beat with nothing outstanding: roll %0d pitch %0d", roll, pitch);
                return;
            end
            d = drive_q.pop_front();
            checked++;
            if (roll !== d.roll) begin
                errors++;
                $error("roll_drive: expected %0d, got %0d", d.roll, roll);
            end
            if (pitch !== d.pitch) begin
                errors++;
                $error("pitch_drive: expected %0d, got %0d", d.pitch, pitch);
            end
        endfunction

        function void check_reg(t_reg_idx idx, logic [APB_DW-1:0] got);
            if (got !== APB_DW'(gain_of(idx))) begin
                errors++;
                $error("%s: expected %0d, got %0d", idx.name(), gain_of(idx), got);
            end
        endfunction

        function int pending();
            return drive_q.size();
        endfunction
    endclass

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_in_valid = 1'b0;
    logic                      o_in_ready;
    logic signed [FIELD_W-1:0] i_target_roll = '0;
    logic signed [FIELD_W-1:0] i_measured_roll = '0;
    logic signed [FIELD_W-1:0] i_rate_x = '0;
    logic signed [FIELD_W-1:0] i_target_pitch = '0;
    logic signed [FIELD_W-1:0] i_measured_pitch = '0;
    logic signed [FIELD_W-1:0] i_rate_y = '0;
    logic        [FIELD_W-1:0] i_sample_time_us = '0;
    logic                      o_out_valid;
    logic                      i_out_ready = 1'b0;
    drive_t                    o_roll_drive;
    drive_t                    o_pitch_drive;
    logic                      psel = 1'b0;
    logic                      penable = 1'b0;
    logic                      pwrite = 1'b0;
    logic [APB_AW-1:0]         paddr = '0;
    logic [APB_DW-1:0]         pwdata = '0;
    logic [APB_DW-1:0]         prdata;
    logic                      pready;

    bit                        in_idle_on = 1'b0;
    bit                        out_idle_on = 1'b0;
    int                        gain_sets = 0;
    drive_scoreboard           sb = new;

    two_axis_attitude_pid_core DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_target_roll    (i_target_roll),
        .i_measured_roll  (i_measured_roll),
        .i_rate_x         (i_rate_x),
        .i_target_pitch   (i_target_pitch),
        .i_measured_pitch (i_measured_pitch),
        .i_rate_y         (i_rate_y),
        .i_sample_time_us (i_sample_time_us),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_roll_drive     (o_roll_drive),
        .o_pitch_drive    (o_pitch_drive),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check_drive(o_roll_drive, o_pitch_drive);
        i_out_ready <= !out_idle_on || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    task automatic apb_write(logic [REG_IW-1:0] idx, logic [APB_DW-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.set_gain(idx, data);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic apb_read(input t_reg_idx idx, output logic [APB_DW-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        data = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic check_gains();
        logic [APB_DW-1:0] rd;
        for (int i = 0; i <= int'(REG_PITCH_KD); i++) begin
            apb_read(t_reg_idx'(i), rd);
            sb.check_reg(t_reg_idx'(i), rd);
        end
    endtask

    // upper data bits carry junk; the spare indexes must not disturb anything
    task automatic load_gains(gain_style_t style);
        logic [GAIN_W-1:0] g;
        for (int i = 0; i <= int'(REG_PITCH_KD); i++) begin
            case (style)
                GAINS_ZERO: g = '0;
                GAINS_MAX:  g = '1;
                default: begin
                    case ($urandom_range(0, 3))
                        0:       g = '0;
                        1:       g = '1;
                        default: g = 16'($urandom);
                    endcase
                end
            endcase
            apb_write(REG_IW'(i), {16'($urandom), g});
        end
        apb_write(REG_SPARE_LO, $urandom);
        apb_write(REG_SPARE_HI, $urandom);
        check_gains();
        gain_sets++;
    endtask

    task automatic send_sample(attitude_sample_t s);
        if (in_idle_on) begin
            while ($urandom_range(0, 99) < IDLE_PCT) begin
                i_in_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_in_valid       <= 1'b1;
        i_target_roll    <= s.tgt_roll;
        i_measured_roll  <= s.meas_roll;
        i_rate_x         <= s.rate_x;
        i_target_pitch   <= s.tgt_pitch;
        i_measured_pitch <= s.meas_pitch;
        i_rate_y         <= s.rate_y;
        i_sample_time_us <= s.dt;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_sample(s);
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic attitude_sample_t directed_sample(int k);
        attitude_sample_t s;
        case (k)
            0: s = '{16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 16'h0000};
            1: s = '{16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'hFFFF};
            2: s = '{16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh8000, 16'hFFFF};
            3: s = '{16'sd1000, -16'sd1000, 16'sh0000, -16'sd5, 16'sd5, 16'sd3, 16'h0000};
            4: s = '{16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh8000, 16'h0001};
            5: s = '{16'sh7FFF, 16'sh7FFF, 16'sh0000, 16'sh7FFF, 16'sh7FFF, 16'sh0000, 16'hFFFF};
            6: s = '{16'sh5555, 16'shAAAA, 16'sh5555, 16'shAAAA, 16'sh5555, 16'shAAAA, 16'hAAAA};
            7: s = '{16'shAAAA, 16'sh5555, 16'shAAAA, 16'sh5555, 16'shAAAA, 16'sh5555, 16'h5555};
            8: s = '{16'sd1, 16'sd0, -16'sd1, -16'sd1, 16'sd0, 16'sd1, 16'h0001};
            default: s = '{16'sh7FFF, 16'sh8000, 16'sh0000, 16'sh8000, 16'sh7FFF, 16'sh0000,
                           16'h0000};
        endcase
        return s;
    endfunction

    function automatic attitude_sample_t gen_sample(gen_mode_t mode, bit up);
        attitude_sample_t s;
        s.tgt_roll   = 16'($urandom);
        s.meas_roll  = 16'($urandom);
        s.rate_x     = 16'($urandom);
        s.tgt_pitch  = 16'($urandom);
        s.meas_pitch = 16'($urandom);
        s.rate_y     = 16'($urandom);
        s.dt         = 16'($urandom);
        case (mode)
            GEN_TRACK: begin
                s.tgt_roll  = s.meas_roll + 16'($urandom_range(0, 64) - 32);
                s.tgt_pitch = s.meas_pitch + 16'($urandom_range(0, 64) - 32);
                s.rate_x    = 16'($urandom_range(0, 400) - 200);
                s.rate_y    = 16'($urandom_range(0, 400) - 200);
                s.dt        = 16'($urandom_range(500, 5000));
            end
            GEN_PUSH: begin
                s.tgt_roll   = {~up, 15'($urandom)};
                s.meas_roll  = {up, 15'($urandom)};
                s.tgt_pitch  = {up, 15'($urandom)};
                s.meas_pitch = {~up, 15'($urandom)};
                s.dt         = 16'($urandom_range(16384, 65535));
            end
            GEN_DT_EDGE: begin
                case ($urandom_range(0, 3))
                    0:       s.dt = '0;
                    1:       s.dt = 16'h0001;
                    2:       s.dt = 16'h8000;
                    default: s.dt = '1;
                endcase
            end
            default: ;
        endcase
        return s;
    endfunction

    initial begin
        attitude_sample_t s;
        gen_mode_t        mode;
        bit               up;
        int               n;
        int               len;
        in_idle_on  = 1'b1;
        out_idle_on = 1'b1;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        check_gains();

        for (int k = 0; k < 10; k++)
            send_sample(directed_sample(k));
        settle();
        load_gains(GAINS_MAX);
        for (int k = 0; k < 10; k++)
            send_sample(directed_sample(k));

        for (int ph = 0; ph < PHASES; ph++) begin
            settle();
            load_gains(ph == 0 ? GAINS_ZERO : (ph == 1 ? GAINS_MAX : GAINS_RANDOM));
            n = 0;
            while (n < PHASE_ITEMS) begin
                mode = gen_mode_t'($urandom_range(0, int'(GEN_DT_EDGE)));
                up   = $urandom_range(0, 1);
                len  = $urandom_range(4, 30);
                repeat (len) begin
                    send_sample(gen_sample(mode, up));
                    n++;
                end
            end
        end

        // wind-up: roll heads for the upper clamp, pitch for the lower
        settle();
        load_gains(GAINS_MAX);
        apb_write(REG_PITCH_KI, $urandom_range(0, 15));
        in_idle_on  = 1'b0;
        out_idle_on = 1'b0;
        s = '{16'sh7FFF, 16'sh8000, 16'sh0000, 16'sh8000, 16'sh7FFF, 16'sh0000, 16'hFFFF};
        repeat (SAT_ITEMS) begin
            s.rate_x = 16'($urandom);
            s.rate_y = 16'($urandom);
            send_sample(s);
        end
        in_idle_on  = 1'b1;
        out_idle_on = 1'b1;
        repeat (40) send_sample(gen_sample(GEN_NOISE, 1'b0));
        settle();

        $display("covered %0d drive beats across %0d gain settings, with %0d back-to-back",
                 sb.checked, gain_sets, SAT_ITEMS);
        $display("beats winding roll up and pitch down; %0d errors seen", sb.errors);
        if (sb.errors == 0) begin
            $display("two_axis_attitude_pid_core: match");
        end else begin
            $display("two_axis_attitude_pid_core: mismatch");
        end
        $finish;
    end

    initial begin
        #(LIMIT_NS);
        $display("two_axis_attitude_pid_core: mismatch");
        $finish;
    end

endmodule
